/* src/sfleg_pkg.sv */
// Shared types, constants and helpers for the support-foot leg odometry block.
// No dependencies; every other file imports this package.
package sfleg_pkg;

    localparam int WORD_W         = 32;
    localparam int THR_W          = 31;
    localparam int AXES           = 3;
    localparam int HIST_DEPTH_DEF = 4;

    // Configuration register indexes
    typedef enum logic {
        CFG_CONTACT_THR = 1'b0,
        CFG_DSUP_THR    = 1'b1
    } t_cfg_idx;

    // Support side codes
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef t_word [AXES-1:0] t_vec3;

    typedef struct packed {
        logic [THR_W-1:0] contact_thr;
        logic [THR_W-1:0] dsup_thr;
    } t_sfleg_cfg;

    typedef struct packed {
        t_word right_force;
        t_word left_force;
        logic  warmup;
        t_word left_ankle_x;
        t_word left_ankle_y;
        t_word left_ankle_z;
        t_word right_ankle_x;
        t_word right_ankle_y;
        t_word right_ankle_z;
        t_word zmp_offset_x;
        t_word zmp_offset_y;
    } t_sfleg_in;

    typedef struct packed {
        logic  support_side;
        t_word support_x;
        t_word support_y;
        t_word support_z;
        t_word com_x;
        t_word com_y;
        t_word com_z;
        t_word zmp_x;
        t_word zmp_y;
        t_word swing_x;
        t_word swing_y;
        t_word swing_z;
    } t_sfleg_out;

    // Signed force strictly above an unsigned threshold; negative never is
    function automatic logic above(input t_word force_v, input logic [THR_W-1:0] thr);
        return !force_v[WORD_W-1] && (force_v[THR_W-1:0] > thr);
    endfunction

endpackage

/* src/sfleg_decide.sv */
// Support side decision with force history and hysteresis.
// Depends on sfleg_pkg.
module sfleg_decide import sfleg_pkg::*; #(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_sfleg_cfg i_cfg,
    input  t_word      i_right_force,
    input  t_word      i_left_force,
    input  logic       i_warmup,
    output logic       o_side,
    output logic       o_state
);

    t_word r_rf_hist [HIST_DEPTH];
    t_word r_lf_hist [HIST_DEPTH];
    logic  r_state;

    logic  rf_contact;
    logic  lf_contact;
    logic  rf_all_high;
    logic  l_any_low;
    logic  side;

    // Evaluate the contact rules, highest priority first
    always_comb begin
        rf_contact  = above(i_right_force, i_cfg.contact_thr);
        lf_contact  = above(i_left_force, i_cfg.contact_thr);
        rf_all_high = rf_contact;
        l_any_low   = !lf_contact;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            rf_all_high = rf_all_high && above(r_rf_hist[i], i_cfg.contact_thr);
            l_any_low   = l_any_low || !above(r_lf_hist[i], i_cfg.contact_thr);
        end
        if ((rf_contact && lf_contact) || i_warmup) begin
            side = SIDE_LEFT;
        end else if (rf_all_high && (r_state == SIDE_LEFT)
                     && !above(i_left_force, i_cfg.dsup_thr)) begin
            side = SIDE_RIGHT;
        end else if (l_any_low && ((r_state == SIDE_RIGHT)
                     || (above(i_right_force, i_cfg.dsup_thr)
                         && above(r_rf_hist[HIST_DEPTH-1], i_cfg.dsup_thr)))) begin
            side = SIDE_RIGHT;
        end else begin
            side = SIDE_LEFT;
        end
    end

    // Remember the side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIDE_LEFT;
        end else if (i_en) begin
            r_state <= side;
        end
    end

    // Shift the force histories, newest at the top entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_rf_hist[i] <= '0;
                r_lf_hist[i] <= '0;
            end
        end else if (i_en) begin
            for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                r_rf_hist[i] <= r_rf_hist[i+1];
                r_lf_hist[i] <= r_lf_hist[i+1];
            end
            r_rf_hist[HIST_DEPTH-1] <= i_right_force;
            r_lf_hist[HIST_DEPTH-1] <= i_left_force;
        end
    end

    assign o_side  = side;
    assign o_state = r_state;

endmodule

/* src/sfleg_pose.sv */
// Foot position state and result computation for one tick.
// Depends on sfleg_pkg.
module sfleg_pose import sfleg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_side,
    input  t_sfleg_in  i_item,
    output t_sfleg_out o_result
);

    t_vec3 r_left_pos;
    t_vec3 r_right_pos;
    t_vec3 la;
    t_vec3 ra;
    t_vec3 sup;
    t_vec3 com;
    t_vec3 swing;

    // Place the swing foot relative to the fixed support foot
    always_comb begin
        la = {i_item.left_ankle_z, i_item.left_ankle_y, i_item.left_ankle_x};
        ra = {i_item.right_ankle_z, i_item.right_ankle_y, i_item.right_ankle_x};
        for (int i = 0; i < AXES; i++) begin
            if (i_side == SIDE_LEFT) begin
                sup[i]   = r_left_pos[i];
                com[i]   = r_left_pos[i] - la[i];
                swing[i] = r_left_pos[i] + (ra[i] - la[i]);
            end else begin
                sup[i]   = r_right_pos[i];
                com[i]   = r_right_pos[i] - ra[i];
                swing[i] = r_right_pos[i] + (la[i] - ra[i]);
            end
        end
    end

    // Update the swing foot only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_pos  <= '0;
            r_right_pos <= '0;
        end else if (i_en) begin
            if (i_side == SIDE_LEFT) begin
                r_right_pos <= swing;
            end else begin
                r_left_pos <= swing;
            end
        end
    end

    // Assemble the result
    always_comb begin
        o_result.support_side = i_side;
        o_result.support_x    = sup[0];
        o_result.support_y    = sup[1];
        o_result.support_z    = sup[2];
        o_result.com_x        = com[0];
        o_result.com_y        = com[1];
        o_result.com_z        = com[2];
        o_result.zmp_x        = i_item.zmp_offset_x + com[0];
        o_result.zmp_y        = i_item.zmp_offset_y + com[1];
        o_result.swing_x      = swing[0];
        o_result.swing_y      = swing[1];
        o_result.swing_z      = swing[2];
    end

endmodule

/* src/support_foot_leg_odometry_core.sv */
// Top level of the support-foot leg odometry block: channels, config, pipeline.
// Depends on sfleg_pkg, sfleg_decide and sfleg_pose.
//
// Takes one tick item per clock cycle while the output side keeps up, and
// returns one result per item: an input register feeds the support
// decision and position update, and the result lands in an output register.
// The decision and foot state advance in the same cycle the item moves into
// the output register, so consecutive items see each other's state without
// bubbles. Input ready drops only when both the input and output registers
// hold items and the output side is stalled. The user writes thresholds through
// the plain write port only while no tick is in flight, unenforced by the block; both reset to zero.
module support_foot_leg_odometry_core import sfleg_pkg::*; #(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [THR_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_sfleg_in        i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_sfleg_out       o_out_data
);

    t_sfleg_cfg r_cfg;
    t_sfleg_in  r_in;
    logic       r_in_valid;
    t_sfleg_out r_out;
    logic       r_out_valid;

    logic       move;
    logic       side;
    logic       state;
    t_sfleg_out result;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_CONTACT_THR: r_cfg.contact_thr <= i_cfg_wdata;
                CFG_DSUP_THR:    r_cfg.dsup_thr    <= i_cfg_wdata;
            endcase
        end
    end

    // Advance an item into the result register when there is room
    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    sfleg_decide #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (move),
        .i_cfg         (r_cfg),
        .i_right_force (r_in.right_force),
        .i_left_force  (r_in.left_force),
        .i_warmup      (r_in.warmup),
        .o_side        (side),
        .o_state       (state)
    );

    sfleg_pose u_pose (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (move),
        .i_side   (side),
        .i_item   (r_in),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // A transfer into the result register always shows up
    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("result lost after move");

    // Warm-up items always report left support
    a_warmup_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in.warmup) |=> (r_out.support_side == SIDE_LEFT))
        else $error("warm-up item did not select left support");

    // The held result agrees with the stored support side
    a_side_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.support_side == state))
        else $error("result side differs from stored side");

endmodule

/* dv/support_foot_leg_odometry_core_tb.sv */
// Self-checking testbench for support_foot_leg_odometry_core: gait-like and random ticks
// against an in-bench support-side and foot-position predictor. Depends on sfleg_pkg.
`timescale 1ns / 1ps

module support_foot_leg_odometry_core_tb;
    import sfleg_pkg::*;

    localparam int          LIMIT_CYCLES = 500000;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          HIST         = 4;
    localparam t_word       FMAX         = 32'sh7FFF_FFFF;
    localparam t_word       FMIN         = 32'sh8000_0000;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    // Force categories relative to the current thresholds
    localparam int F_LOW    = 0;
    localparam int F_MID    = 1;
    localparam int F_HIGH   = 2;
    localparam int F_ANY    = 3;
    localparam int F_CORNER = 4;

    // Gait phases
    localparam int PH_RIGHT    = 0;
    localparam int PH_DOUBLE_A = 1;
    localparam int PH_LEFT     = 2;
    localparam int PH_DOUBLE_B = 3;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    t_cfg_idx         cfg_idx;
    logic [THR_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    t_sfleg_in        in_data;
    logic             out_valid;
    logic             out_ready;
    t_sfleg_out       out_data;

    // Predictor state
    logic [THR_W-1:0] contact_thr_m;
    logic [THR_W-1:0] dsup_thr_m;
    logic             side_m;
    t_word            left_pos_m[AXES];
    t_word            right_pos_m[AXES];
    t_word            right_hist_m[HIST];
    t_word            left_hist_m[HIST];

    t_sfleg_out       pending_poses[$];
    int               mismatch_count;
    bit               no_idle;
    longint           cycle_count;

    support_foot_leg_odometry_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("support_foot_leg_odometry_core_tb: FAIL");
            $finish;
        end
    end

    // Stall the result side at random unless a no-idle stretch runs
    always @(negedge clk) begin
        out_ready <= rst_n && (no_idle || $urandom_range(0, 99) >= 10);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Compare each result transfer with the oldest predicted pose
    always @(posedge clk) begin
        t_sfleg_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_poses.size() == 0) begin
                report_mismatch("result transfer with no tick pending");
            end else begin
                want = pending_poses.pop_front();
                check_field("support_side", WORD_W'(out_data.support_side),
                            WORD_W'(want.support_side));
                check_field("support_x", out_data.support_x, want.support_x);
                check_field("support_y", out_data.support_y, want.support_y);
                check_field("support_z", out_data.support_z, want.support_z);
                check_field("com_x", out_data.com_x, want.com_x);
                check_field("com_y", out_data.com_y, want.com_y);
                check_field("com_z", out_data.com_z, want.com_z);
                check_field("zmp_x", out_data.zmp_x, want.zmp_x);
                check_field("zmp_y", out_data.zmp_y, want.zmp_y);
                check_field("swing_x", out_data.swing_x, want.swing_x);
                check_field("swing_y", out_data.swing_y, want.swing_y);
                check_field("swing_z", out_data.swing_z, want.swing_z);
            end
        end
    end

    // Signed force strictly above an unsigned threshold
    function automatic bit exceeds(input t_word force_v, input logic [THR_W-1:0] thr);
        return longint'(force_v) > longint'({1'b0, thr});
    endfunction

    // Decide the support side, move the swing foot and shift the force history
    function automatic t_sfleg_out step_odometry(input t_sfleg_in it);
        t_word      la[AXES];
        t_word      ra[AXES];
        t_word      sup[AXES];
        t_word      com[AXES];
        t_word      swing[AXES];
        logic       side;
        bit         r_all;
        bit         l_low;
        t_sfleg_out res;
        la[0] = it.left_ankle_x;
        la[1] = it.left_ankle_y;
        la[2] = it.left_ankle_z;
        ra[0] = it.right_ankle_x;
        ra[1] = it.right_ankle_y;
        ra[2] = it.right_ankle_z;

        if ((exceeds(it.right_force, contact_thr_m) && exceeds(it.left_force, contact_thr_m))
                || it.warmup) begin
            side = SIDE_LEFT;
        end else begin
            r_all = exceeds(it.right_force, contact_thr_m);
            l_low = !exceeds(it.left_force, contact_thr_m);
            for (int i = 0; i < HIST; i++) begin
                if (!exceeds(right_hist_m[i], contact_thr_m))
                    r_all = 0;
                if (!exceeds(left_hist_m[i], contact_thr_m))
                    l_low = 1;
            end
            if (r_all && side_m == SIDE_LEFT && !exceeds(it.left_force, dsup_thr_m))
                side = SIDE_RIGHT;
            else if (l_low && (side_m == SIDE_RIGHT ||
                     (exceeds(it.right_force, dsup_thr_m) &&
                      exceeds(right_hist_m[HIST-1], dsup_thr_m))))
                side = SIDE_RIGHT;
            else
                side = SIDE_LEFT;
        end

        // Hold the support foot, place the swing foot by the ankle difference
        for (int i = 0; i < AXES; i++) begin
            if (side == SIDE_LEFT) begin
                right_pos_m[i] = left_pos_m[i] + (ra[i] - la[i]);
                sup[i]         = left_pos_m[i];
                com[i]         = left_pos_m[i] - la[i];
                swing[i]       = right_pos_m[i];
            end else begin
                left_pos_m[i] = right_pos_m[i] + (la[i] - ra[i]);
                sup[i]        = right_pos_m[i];
                com[i]        = right_pos_m[i] - ra[i];
                swing[i]      = left_pos_m[i];
            end
        end
        side_m = side;

        for (int i = 0; i < HIST - 1; i++) begin
            right_hist_m[i] = right_hist_m[i+1];
            left_hist_m[i]  = left_hist_m[i+1];
        end
        right_hist_m[HIST-1] = it.right_force;
        left_hist_m[HIST-1]  = it.left_force;

        res.support_side = side;
        res.support_x    = sup[0];
        res.support_y    = sup[1];
        res.support_z    = sup[2];
        res.com_x        = com[0];
        res.com_y        = com[1];
        res.com_z        = com[2];
        res.zmp_x        = it.zmp_offset_x + com[0];
        res.zmp_y        = it.zmp_offset_y + com[1];
        res.swing_x      = swing[0];
        res.swing_y      = swing[1];
        res.swing_z      = swing[2];
        return res;
    endfunction

    // Present one tick and hold it until the transfer, then predict its pose
    task automatic send_tick(input t_sfleg_in item);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        pending_poses.push_back(step_odometry(item));
    endtask

    // Drop valid and let every pending result come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [THR_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_CONTACT_THR: contact_thr_m = val;
            CFG_DSUP_THR:    dsup_thr_m    = val;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] contact, input logic [THR_W-1:0] dsup);
        write_reg(CFG_CONTACT_THR, contact);
        write_reg(CFG_DSUP_THR, dsup);
    endtask

    function automatic t_word clamp_word(input longint v);
        if (v > longint'(FMAX))
            return FMAX;
        if (v < longint'(FMIN))
            return FMIN;
        return t_word'(v);
    endfunction

    // Pick a force below, between or above the thresholds, or anywhere
    function automatic t_word pick_force(input int cat);
        case (cat)
            F_LOW:  return clamp_word(longint'(contact_thr_m) - $urandom_range(0, 4000));
            F_MID:  return clamp_word(longint'(contact_thr_m) + 1 + $urandom_range(0, 4000));
            F_HIGH: return clamp_word(longint'(dsup_thr_m) + 1 + $urandom_range(0, 4000));
            F_ANY:  return t_word'($urandom);
            default: begin
                case ($urandom_range(0, 6))
                    0:       return 0;
                    1:       return 1;
                    2:       return -1;
                    3:       return FMAX;
                    4:       return FMIN;
                    5:       return t_word'({1'b0, contact_thr_m});
                    default: return clamp_word(longint'(dsup_thr_m) + 1);
                endcase
            end
        endcase
    endfunction

    function automatic t_sfleg_in make_tick(input t_word rf, input t_word lf, input logic warm);
        t_sfleg_in t;
        t.right_force   = rf;
        t.left_force    = lf;
        t.warmup        = warm;
        t.left_ankle_x  = t_word'($urandom);
        t.left_ankle_y  = t_word'($urandom);
        t.left_ankle_z  = t_word'($urandom);
        t.right_ankle_x = t_word'($urandom);
        t.right_ankle_y = t_word'($urandom);
        t.right_ankle_z = t_word'($urandom);
        t.zmp_offset_x  = t_word'($urandom);
        t.zmp_offset_y  = t_word'($urandom);
        return t;
    endfunction

    // Loaded foot mostly high, unloaded foot mostly low, with some noise
    function automatic t_sfleg_in gait_tick(input int phase);
        int rcat;
        int lcat;
        rcat = ($urandom_range(0, 99) < 80) ? F_HIGH : F_MID;
        lcat = ($urandom_range(0, 99) < 80) ? F_LOW : F_MID;
        case (phase)
            PH_LEFT: begin
                lcat = rcat;
                rcat = ($urandom_range(0, 99) < 80) ? F_LOW : F_MID;
            end
            PH_DOUBLE_A, PH_DOUBLE_B: begin
                rcat = $urandom_range(F_MID, F_HIGH);
                lcat = $urandom_range(F_MID, F_HIGH);
            end
            default: ;
        endcase
        if ($urandom_range(0, 99) < 5)
            rcat = $urandom_range(F_ANY, F_CORNER);
        if ($urandom_range(0, 99) < 5)
            lcat = $urandom_range(F_ANY, F_CORNER);
        return make_tick(pick_force(rcat), pick_force(lcat), 1'b0);
    endfunction

    // Warm up, then step through stance and double-support phases
    task automatic walk(input int n_ticks);
        int done;
        int len;
        int phase;
        done  = 0;
        phase = $urandom_range(PH_RIGHT, PH_DOUBLE_B);
        for (int k = 0; k < 5; k++)
            send_tick(make_tick(pick_force($urandom_range(F_LOW, F_CORNER)),
                                pick_force($urandom_range(F_LOW, F_CORNER)), 1'b1));
        while (done < n_ticks) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len && done < n_ticks; k++) begin
                send_tick(gait_tick(phase));
                done++;
            end
            phase = (phase + 1) % 4;
        end
    endtask

    task automatic test_directed();
        t_sfleg_in t;
        set_thresholds(31'd6553600, 31'd19660800);
        send_tick(make_tick(0, 0, 1'b1));

        // Extreme forces and ankle offsets during warm-up; positions wrap
        t = make_tick(FMAX, FMIN, 1'b1);
        t.left_ankle_x  = FMAX; t.left_ankle_y  = FMAX; t.left_ankle_z  = FMAX;
        t.right_ankle_x = FMIN; t.right_ankle_y = FMIN; t.right_ankle_z = FMIN;
        t.zmp_offset_x  = FMAX; t.zmp_offset_y  = FMAX;
        send_tick(t);
        t = make_tick(FMIN, FMAX, 1'b1);
        t.left_ankle_x  = FMIN; t.left_ankle_y  = FMIN; t.left_ankle_z  = FMIN;
        t.right_ankle_x = FMAX; t.right_ankle_y = FMAX; t.right_ankle_z = FMAX;
        t.zmp_offset_x  = FMIN; t.zmp_offset_y  = FMIN;
        send_tick(t);

        // Both feet loaded, then right loading until the switch to right support
        send_tick(make_tick(32'sd19660805, 32'sd19660805, 1'b0));
        for (int k = 0; k < 5; k++)
            send_tick(make_tick(32'sd19661800, 32'sd6553600, 1'b0));

        // Stay right while the left history is low; negative forces never count
        send_tick(make_tick(32'sd6553601, -1, 1'b0));
        send_tick(make_tick(-1, FMIN, 1'b0));
        send_tick(make_tick(FMIN, 32'sd19660800, 1'b0));

        // Left loads for long enough to take support back
        for (int k = 0; k < 5; k++)
            send_tick(make_tick(0, 32'sd19660801, 1'b0));

        // Forces exactly at each threshold, and a warm-up tick forcing left
        send_tick(make_tick(32'sd19660800, 32'sd19660800, 1'b0));
        send_tick(make_tick(32'sd6553600, 32'sd6553600, 1'b0));
        send_tick(make_tick(FMAX, 0, 1'b1));
        wait_drain();
    endtask

    // Zero and full-scale thresholds in every combination
    task automatic test_threshold_extremes();
        logic [THR_W-1:0] ct[4];
        logic [THR_W-1:0] dt[4];
        ct = '{'0, THR_MAX, '0, THR_MAX};
        dt = '{'0, THR_MAX, THR_MAX, '0};
        for (int s = 0; s < 4; s++) begin
            set_thresholds(ct[s], dt[s]);
            for (int k = 0; k < 50; k++)
                send_tick(make_tick(pick_force($urandom_range(F_LOW, F_CORNER)),
                                    pick_force($urandom_range(F_LOW, F_CORNER)),
                                    $urandom_range(0, 99) < 10));
            wait_drain();
        end
    endtask

    // Gait-shaped walks, each under fresh thresholds
    task automatic test_gait_walks(input int n_ticks);
        int done;
        int len;
        logic [THR_W-1:0] contact;
        logic [THR_W-1:0] dsup;
        done = 0;
        while (done < n_ticks) begin
            contact = THR_W'($urandom_range(0, 1 << 22));
            if ($urandom_range(0, 99) < 10)
                dsup = THR_W'($urandom_range(0, 1 << 22));
            else
                dsup = THR_W'(contact + $urandom_range(0, 1 << 22));
            set_thresholds(contact, dsup);
            len = $urandom_range(30, 120);
            walk(len);
            done += len;
            wait_drain();
        end
    endtask

    // Long stretch with both sides always ready
    task automatic test_back_to_back(input int n_ticks);
        set_thresholds(31'd3276800, 31'd9830400);
        no_idle = 1;
        walk(n_ticks);
        wait_drain();
        no_idle = 0;
    endtask

    // Unshaped ticks: random forces, warm-up flag and offsets
    task automatic test_noise(input int n_ticks);
        set_thresholds(THR_W'($urandom), THR_W'($urandom_range(0, 1 << 24)));
        for (int k = 0; k < n_ticks; k++)
            send_tick(make_tick(pick_force($urandom_range(F_ANY, F_CORNER)),
                                pick_force($urandom_range(F_LOW, F_CORNER)),
                                1'($urandom_range(0, 1))));
        wait_drain();
    endtask

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_idx        = CFG_CONTACT_THR;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        mismatch_count = 0;
        no_idle        = 0;
        cycle_count    = 0;
        contact_thr_m  = '0;
        dsup_thr_m     = '0;
        side_m         = SIDE_LEFT;
        for (int i = 0; i < AXES; i++) begin
            left_pos_m[i]  = '0;
            right_pos_m[i] = '0;
        end
        for (int i = 0; i < HIST; i++) begin
            right_hist_m[i] = '0;
            left_hist_m[i]  = '0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_threshold_extremes();
        test_gait_walks(1200);
        test_back_to_back(300);
        test_noise(300);
        wait_drain();

        if (mismatch_count == 0)
            $display("support_foot_leg_odometry_core_tb: PASS");
        else
            $display("support_foot_leg_odometry_core_tb: FAIL");
        $finish;
    end

endmodule
